>>> sv/aes256_pkg.sv
// Package with AES-256 CBC types, constants and byte-level functions.
package aes256_pkg;

    localparam int BlockW   = 128;
    localparam int WordW    = 64;
    localparam int NumRk    = 15;
    localparam int RkIdxW   = 4;
    localparam int CfgIdxW  = 3;
    localparam int ExpStepW = 6;

    // Configuration register indexes.
    localparam logic [CfgIdxW-1:0] REG_KEY0    = 3'd0;
    localparam logic [CfgIdxW-1:0] REG_KEY1    = 3'd1;
    localparam logic [CfgIdxW-1:0] REG_KEY2    = 3'd2;
    localparam logic [CfgIdxW-1:0] REG_KEY3    = 3'd3;
    localparam logic [CfgIdxW-1:0] REG_IV_HIGH = 3'd4;
    localparam logic [CfgIdxW-1:0] REG_IV_LOW  = 3'd5;

    // Command codes.
    localparam logic CMD_ENCRYPT = 1'b0;
    localparam logic CMD_DECRYPT = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXPAND,
        ST_LOAD,
        ST_ROUND,
        ST_DONE
    } aes_state_t;

    typedef logic [7:0] byte_t;

    localparam logic [7:0] SBOX_FWD [256] = '{
        8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
        8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
        8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
        8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
        8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
        8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
        8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
        8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
        8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
        8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
        8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
        8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
        8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
        8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
        8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
        8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
    };

    localparam logic [7:0] SBOX_INV [256] = '{
        8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
        8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
        8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
        8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
        8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
        8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
        8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
        8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
        8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
        8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
        8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
        8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
        8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
        8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
        8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
        8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d
    };

    localparam logic [7:0] RCON [8] = '{
        8'h00, 8'h01, 8'h02, 8'h04, 8'h08, 8'h10, 8'h20, 8'h40
    };

    // Multiply by x in GF(2^8).
    function automatic byte_t xtime(input byte_t a);
        return a[7] ? ({a[6:0], 1'b0} ^ 8'h1b) : {a[6:0], 1'b0};
    endfunction

    // Byte i of a 128-bit block, byte 0 in the top bits.
    function automatic byte_t get_byte(input logic [BlockW-1:0] s, input int i);
        return s[BlockW-1-8*i -: 8];
    endfunction

    // Forward round: SubBytes, ShiftRows, optional MixColumns.
    function automatic logic [BlockW-1:0] enc_round(input logic [BlockW-1:0] s,
                                                    input logic mix);
        byte_t t [16];
        byte_t u [16];
        byte_t a, b, d, e;
        logic [BlockW-1:0] r;
        for (int i = 0; i < 16; i++) t[i] = SBOX_FWD[get_byte(s, i)];
        for (int c = 0; c < 4; c++)
            for (int i = 0; i < 4; i++) u[4*c+i] = t[4*((c+i)%4)+i];
        if (mix) begin
            for (int c = 0; c < 4; c++) begin
                a = u[4*c]; b = u[4*c+1]; d = u[4*c+2]; e = u[4*c+3];
                u[4*c]   = xtime(a) ^ xtime(b) ^ b ^ d ^ e;
                u[4*c+1] = a ^ xtime(b) ^ xtime(d) ^ d ^ e;
                u[4*c+2] = a ^ b ^ xtime(d) ^ xtime(e) ^ e;
                u[4*c+3] = xtime(a) ^ a ^ b ^ d ^ xtime(e);
            end
        end
        for (int i = 0; i < 16; i++) r[BlockW-1-8*i -: 8] = u[i];
        return r;
    endfunction

    // Inverse ShiftRows and SubBytes.
    function automatic logic [BlockW-1:0] dec_sub(input logic [BlockW-1:0] s);
        byte_t u [16];
        logic [BlockW-1:0] r;
        for (int c = 0; c < 4; c++)
            for (int i = 0; i < 4; i++) u[4*((c+i)%4)+i] = get_byte(s, 4*c+i);
        for (int i = 0; i < 16; i++) r[BlockW-1-8*i -: 8] = SBOX_INV[u[i]];
        return r;
    endfunction

    // Inverse MixColumns.
    function automatic logic [BlockW-1:0] inv_mix(input logic [BlockW-1:0] s);
        byte_t x [4];
        byte_t m2 [4];
        byte_t m4 [4];
        byte_t m8 [4];
        byte_t m9 [4];
        byte_t mb [4];
        byte_t md [4];
        byte_t me [4];
        logic [BlockW-1:0] r;
        for (int c = 0; c < 4; c++) begin
            for (int j = 0; j < 4; j++) begin
                x[j]  = get_byte(s, 4*c+j);
                m2[j] = xtime(x[j]);
                m4[j] = xtime(m2[j]);
                m8[j] = xtime(m4[j]);
                m9[j] = m8[j] ^ x[j];
                mb[j] = m8[j] ^ m2[j] ^ x[j];
                md[j] = m8[j] ^ m4[j] ^ x[j];
                me[j] = m8[j] ^ m4[j] ^ m2[j];
            end
            r[BlockW-1-8*(4*c)   -: 8] = me[0] ^ mb[1] ^ md[2] ^ m9[3];
            r[BlockW-1-8*(4*c+1) -: 8] = m9[0] ^ me[1] ^ mb[2] ^ md[3];
            r[BlockW-1-8*(4*c+2) -: 8] = md[0] ^ m9[1] ^ me[2] ^ mb[3];
            r[BlockW-1-8*(4*c+3) -: 8] = mb[0] ^ md[1] ^ m9[2] ^ me[3];
        end
        return r;
    endfunction

endpackage

>>> sv/aes256_cbc_block_cipher_top.sv
// Top level of the AES-256 CBC block cipher with an iterative round unit.
//
//  Channel   Direction  Handshake          Payload
//  in        input      in_valid/in_ready  command, restart_chain, block_high, block_low
//  out       output     out_valid/out_ready result_high, result_low
//  cfg       input      cfg_we             cfg_index, cfg_data
//
// An item is accepted in idle; the load state reads the first round key, the round states
// follow (initial key add, then 14 rounds), and the done state holds the result valid.
// A new item is accepted only after the result has been taken and the unit is idle again.
// A key write is followed by expansion of 60 round key words from idle, one 32-bit word a cycle.
// Reset clears control state and the chain value; the key store is filled by expansion.
// While out_ready is low the result is held and the next item waits.
module aes256_cbc_block_cipher_top (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  logic                       command,
    input  logic                       restart_chain,
    input  logic [aes256_pkg::WordW-1:0] block_high,
    input  logic [aes256_pkg::WordW-1:0] block_low,
    output logic                       out_valid,
    input  logic                       out_ready,
    output logic [aes256_pkg::WordW-1:0] result_high,
    output logic [aes256_pkg::WordW-1:0] result_low,
    input  logic                       cfg_we,
    input  logic [aes256_pkg::CfgIdxW-1:0] cfg_index,
    input  logic [aes256_pkg::WordW-1:0] cfg_data
);
    import aes256_pkg::*;

    aes_state_t state_reg, state_next;

    logic [WordW-1:0]  key_reg [4];
    logic [BlockW-1:0] iv_reg;
    logic [BlockW-1:0] chain_reg;
    logic [BlockW-1:0] data_reg;
    logic [BlockW-1:0] blk_reg;
    logic              cmd_reg;
    logic [RkIdxW-1:0] round_reg;
    logic              expand_pend_reg;

    // Key expansion: eight-word window, word counter.
    logic [31:0]        win_reg [8];
    logic [ExpStepW-1:0] exp_reg;
    logic [31:0]        exp_word;
    logic [31:0]        exp_t;

    // Round key memory, four words per entry written one word a cycle.
    logic [BlockW-1:0] rk_mem [NumRk];
    logic [95:0]       rk_asm_reg;
    logic [BlockW-1:0] rk_q;
    logic [RkIdxW-1:0] rk_raddr;

    logic in_fire, out_fire, key_write;

    assign in_fire   = in_valid & in_ready;
    assign out_fire  = out_valid & out_ready;
    assign key_write = cfg_we & (cfg_index == REG_KEY0 || cfg_index == REG_KEY1 ||
                                 cfg_index == REG_KEY2 || cfg_index == REG_KEY3);

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (expand_pend_reg)
                    state_next = ST_EXPAND;
                else if (in_valid)
                    state_next = ST_LOAD;
            end
            ST_EXPAND:
            begin
                if (exp_reg == ExpStepW'(59))
                    state_next = ST_IDLE;
            end
            ST_LOAD:
                state_next = ST_ROUND;
            ST_ROUND:
            begin
                if (round_reg == RkIdxW'(NumRk-1))
                    state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (out_ready)
                    state_next = ST_IDLE;
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    // Outputs of the sequencer.
    always_comb
    begin
        in_ready  = (state_reg == ST_IDLE) & ~expand_pend_reg;
        out_valid = (state_reg == ST_DONE);
    end

    assign result_high = data_reg[BlockW-1 -: WordW];
    assign result_low  = data_reg[WordW-1:0];

    // Round key read address: encrypt walks up, decrypt walks down.
    always_comb
    begin
        if (state_reg == ST_LOAD)
            rk_raddr = (cmd_reg == CMD_DECRYPT) ? RkIdxW'(NumRk-1) : '0;
        else if (cmd_reg == CMD_DECRYPT)
            rk_raddr = RkIdxW'(NumRk-2) - round_reg;
        else
            rk_raddr = round_reg + RkIdxW'(1);
    end

    always_ff @(posedge clk)
    begin
        rk_q <= rk_mem[rk_raddr];
        if (state_reg == ST_EXPAND && exp_reg[1:0] == 2'd3)
            rk_mem[exp_reg[ExpStepW-1:2]] <= {rk_asm_reg, exp_word};
    end

    // Key schedule word for the current expansion step.
    always_comb
    begin
        exp_t = win_reg[7];
        if (exp_reg[2:0] == 3'd0)
            exp_t = {SBOX_FWD[exp_t[23:16]] ^ RCON[exp_reg[5:3]], SBOX_FWD[exp_t[15:8]],
                     SBOX_FWD[exp_t[7:0]], SBOX_FWD[exp_t[31:24]]};
        else if (exp_reg[2:0] == 3'd4)
            exp_t = {SBOX_FWD[exp_t[31:24]], SBOX_FWD[exp_t[23:16]],
                     SBOX_FWD[exp_t[15:8]], SBOX_FWD[exp_t[7:0]]};
        if (exp_reg < ExpStepW'(8))
            exp_word = (exp_reg[2] == 1'b0)
                ? ((exp_reg[1] == 1'b0) ? key_reg[0][63-32*exp_reg[0] -: 32]
                                        : key_reg[1][63-32*exp_reg[0] -: 32])
                : ((exp_reg[1] == 1'b0) ? key_reg[2][63-32*exp_reg[0] -: 32]
                                        : key_reg[3][63-32*exp_reg[0] -: 32]);
        else
            exp_word = win_reg[0] ^ exp_t;
    end

    // Expansion registers.
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_EXPAND)
        begin
            rk_asm_reg <= {rk_asm_reg[63:0], exp_word};
            for (int i = 0; i < 7; i++) win_reg[i] <= win_reg[i+1];
            win_reg[7] <= exp_word;
        end
    end

    // Control, chain and configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            expand_pend_reg <= 1'b0;
            exp_reg         <= '0;
            round_reg       <= '0;
            chain_reg       <= '0;
            iv_reg          <= '0;
            for (int i = 0; i < 4; i++) key_reg[i] <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_we)
            begin
                unique case (cfg_index)
                    REG_KEY0:    key_reg[0] <= cfg_data;
                    REG_KEY1:    key_reg[1] <= cfg_data;
                    REG_KEY2:    key_reg[2] <= cfg_data;
                    REG_KEY3:    key_reg[3] <= cfg_data;
                    REG_IV_HIGH: iv_reg[BlockW-1 -: WordW] <= cfg_data;
                    REG_IV_LOW:  iv_reg[WordW-1:0] <= cfg_data;
                    default:     ;
                endcase
            end
            if (key_write)
                expand_pend_reg <= 1'b1;
            else if (state_reg == ST_IDLE && expand_pend_reg)
                expand_pend_reg <= 1'b0;
            if (state_reg == ST_EXPAND)
                exp_reg <= exp_reg + ExpStepW'(1);
            else
                exp_reg <= '0;
            if (state_reg == ST_ROUND)
                round_reg <= round_reg + RkIdxW'(1);
            else
                round_reg <= '0;
            if (in_fire && restart_chain)
                chain_reg <= iv_reg;
            // The finished block is in the data register while the result waits.
            if (state_reg == ST_DONE && out_fire)
                chain_reg <= (cmd_reg == CMD_DECRYPT) ? blk_reg : data_reg;
        end
    end

    // Round unit: one round per cycle on the data register.
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            cmd_reg  <= command;
            blk_reg  <= {block_high, block_low};
            data_reg <= {block_high, block_low} ^
                        ((command == CMD_ENCRYPT)
                         ? (restart_chain ? iv_reg : chain_reg) : '0);
        end
        else if (state_reg == ST_ROUND)
        begin
            if (round_reg == '0)
                data_reg <= data_reg ^ rk_q;
            else if (cmd_reg == CMD_ENCRYPT)
                data_reg <= enc_round(data_reg, round_reg != RkIdxW'(NumRk-1)) ^ rk_q;
            else if (round_reg == RkIdxW'(NumRk-1))
                data_reg <= dec_sub(data_reg) ^ rk_q ^ chain_reg;
            else
                data_reg <= inv_mix(dec_sub(data_reg) ^ rk_q);
        end
        else if (state_reg == ST_DONE && out_fire)
            data_reg <= data_reg;
    end

endmodule

>>> tb/sv/tb_aes256_cbc_block_cipher_top.sv
// Testbench for the AES-256 CBC block cipher top level with a self-checking scoreboard.
`timescale 1ns / 100ps

// Holds a copy of the key, the IV and the chain value, predicts each result, and checks it.
class cbc_scoreboard;
    logic [63:0]  key_regs [4];
    logic [63:0]  iv_regs [2];
    logic [7:0]   round_keys [15][16];
    logic [7:0]   chain [16];
    logic [127:0] pending_blocks [$];
    int           errors;
    int           checked;
    int           enc_count;
    int           dec_count;

    function new();
        foreach (key_regs[i]) key_regs[i] = '0;
        iv_regs[0] = '0;
        iv_regs[1] = '0;
        foreach (round_keys[r, i]) round_keys[r][i] = 8'h00;
        foreach (chain[i]) chain[i] = 8'h00;
        errors = 0;
        checked = 0;
        enc_count = 0;
        dec_count = 0;
    endfunction

    // Print one mismatch line and count it.
    task report(string msg);
        errors++;
        $display("MISMATCH at %0t: %s", $time, msg);
    endtask

    static function logic [7:0] gmul(logic [7:0] a, logic [7:0] b);
        logic [7:0] p;
        p = 8'h00;
        for (int i = 0; i < 8; i++) begin
            if (b[0]) p ^= a;
            a = a[7] ? ({a[6:0], 1'b0} ^ 8'h1b) : {a[6:0], 1'b0};
            b = b >> 1;
        end
        return p;
    endfunction

    // Rebuild all 15 round keys from the four key registers.
    function void expand_schedule();
        logic [7:0] w [240];
        logic [7:0] t [4];
        logic [7:0] first;
        logic [127:0] lo_half;
        logic [127:0] hi_half;
        lo_half = {key_regs[0], key_regs[1]};
        hi_half = {key_regs[2], key_regs[3]};
        for (int i = 0; i < 16; i++) begin
            w[i]      = lo_half[127-8*i -: 8];
            w[16 + i] = hi_half[127-8*i -: 8];
        end
        for (int i = 8; i < 60; i++) begin
            for (int j = 0; j < 4; j++) t[j] = w[(i-1)*4 + j];
            if ((i % 8) == 0) begin
                first = t[0];
                t[0] = aes256_pkg::SBOX_FWD[t[1]] ^ aes256_pkg::RCON[(i >> 3) & 7];
                t[1] = aes256_pkg::SBOX_FWD[t[2]];
                t[2] = aes256_pkg::SBOX_FWD[t[3]];
                t[3] = aes256_pkg::SBOX_FWD[first];
            end
            else if ((i % 8) == 4) begin
                for (int j = 0; j < 4; j++) t[j] = aes256_pkg::SBOX_FWD[t[j]];
            end
            for (int j = 0; j < 4; j++) w[i*4 + j] = w[(i-8)*4 + j] ^ t[j];
        end
        for (int r = 0; r < 15; r++)
            for (int i = 0; i < 16; i++) round_keys[r][i] = w[16*r + i];
    endfunction

    // Mirror a register write; unknown indexes are ignored.
    function void write_reg(logic [aes256_pkg::CfgIdxW-1:0] idx, logic [63:0] value);
        case (idx)
            aes256_pkg::REG_KEY0:    begin key_regs[0] = value; expand_schedule(); end
            aes256_pkg::REG_KEY1:    begin key_regs[1] = value; expand_schedule(); end
            aes256_pkg::REG_KEY2:    begin key_regs[2] = value; expand_schedule(); end
            aes256_pkg::REG_KEY3:    begin key_regs[3] = value; expand_schedule(); end
            aes256_pkg::REG_IV_HIGH: iv_regs[0] = value;
            aes256_pkg::REG_IV_LOW:  iv_regs[1] = value;
            default: ;
        endcase
    endfunction

    function void forward_cipher(ref logic [7:0] s [16]);
        logic [7:0] t [16];
        logic [7:0] a, b, d, e;
        for (int i = 0; i < 16; i++) s[i] ^= round_keys[0][i];
        for (int r = 1; r <= 14; r++) begin
            for (int i = 0; i < 16; i++) t[i] = aes256_pkg::SBOX_FWD[s[i]];
            for (int c = 0; c < 4; c++)
                for (int i = 0; i < 4; i++) s[4*c+i] = t[4*((c+i)%4)+i];
            if (r < 14) begin
                for (int c = 0; c < 4; c++) begin
                    a = s[4*c]; b = s[4*c+1]; d = s[4*c+2]; e = s[4*c+3];
                    s[4*c]   = gmul(2, a) ^ gmul(3, b) ^ d ^ e;
                    s[4*c+1] = a ^ gmul(2, b) ^ gmul(3, d) ^ e;
                    s[4*c+2] = a ^ b ^ gmul(2, d) ^ gmul(3, e);
                    s[4*c+3] = gmul(3, a) ^ b ^ d ^ gmul(2, e);
                end
            end
            for (int i = 0; i < 16; i++) s[i] ^= round_keys[r][i];
        end
    endfunction

    function void inverse_cipher(ref logic [7:0] s [16]);
        logic [7:0] t [16];
        logic [7:0] a, b, d, e;
        for (int i = 0; i < 16; i++) s[i] ^= round_keys[14][i];
        for (int r = 13; r >= 0; r--) begin
            for (int i = 0; i < 16; i++) t[i] = s[i];
            for (int c = 0; c < 4; c++)
                for (int i = 0; i < 4; i++) s[4*((c+i)%4)+i] = t[4*c+i];
            for (int i = 0; i < 16; i++) s[i] = aes256_pkg::SBOX_INV[s[i]];
            for (int i = 0; i < 16; i++) s[i] ^= round_keys[r][i];
            if (r > 0) begin
                for (int c = 0; c < 4; c++) begin
                    a = s[4*c]; b = s[4*c+1]; d = s[4*c+2]; e = s[4*c+3];
                    s[4*c]   = gmul(8'h0e, a) ^ gmul(8'h0b, b) ^ gmul(8'h0d, d) ^ gmul(8'h09, e);
                    s[4*c+1] = gmul(8'h09, a) ^ gmul(8'h0e, b) ^ gmul(8'h0b, d) ^ gmul(8'h0d, e);
                    s[4*c+2] = gmul(8'h0d, a) ^ gmul(8'h09, b) ^ gmul(8'h0e, d) ^ gmul(8'h0b, e);
                    s[4*c+3] = gmul(8'h0b, a) ^ gmul(8'h0d, b) ^ gmul(8'h09, d) ^ gmul(8'h0e, e);
                end
            end
        end
    endfunction

    // Predict the output block of one accepted item and queue it.
    function logic [127:0] note_input(logic cmd, logic restart, logic [63:0] hi, logic [63:0] lo);
        logic [7:0]   blk [16];
        logic [7:0]   s [16];
        logic [127:0] iv_all;
        logic [127:0] in_all;
        logic [127:0] out_all;
        iv_all = {iv_regs[0], iv_regs[1]};
        in_all = {hi, lo};
        if (restart)
            for (int i = 0; i < 16; i++) chain[i] = iv_all[127-8*i -: 8];
        for (int i = 0; i < 16; i++) blk[i] = in_all[127-8*i -: 8];
        if (cmd == aes256_pkg::CMD_ENCRYPT) begin
            for (int i = 0; i < 16; i++) s[i] = blk[i] ^ chain[i];
            forward_cipher(s);
            for (int i = 0; i < 16; i++) chain[i] = s[i];
            enc_count++;
        end
        else begin
            for (int i = 0; i < 16; i++) s[i] = blk[i];
            inverse_cipher(s);
            for (int i = 0; i < 16; i++) s[i] ^= chain[i];
            for (int i = 0; i < 16; i++) chain[i] = blk[i];
            dec_count++;
        end
        for (int i = 0; i < 16; i++) out_all[127-8*i -: 8] = s[i];
        pending_blocks.insert(pending_blocks.size(), out_all);
        return out_all;
    endfunction

    // Compare one accepted result with the oldest prediction.
    task check_result(logic [63:0] hi, logic [63:0] lo);
        logic [127:0] want;
        if (pending_blocks.size() == 0) begin
            report($sformatf("unexpected result %h_%h", hi, lo));
        end
        else begin
            want = pending_blocks.pop_front();
            checked++;
            if (hi !== want[127:64])
                report($sformatf("result_high %h, expected %h", hi, want[127:64]));
            if (lo !== want[63:0])
                report($sformatf("result_low %h, expected %h", lo, want[63:0]));
        end
    endtask
endclass

module tb_aes256_cbc_block_cipher_top;
    import aes256_pkg::*;

    logic                clk;
    logic                rst_n;
    logic                in_valid;
    logic                in_ready;
    logic                command;
    logic                restart_chain;
    logic [WordW-1:0]    block_high;
    logic [WordW-1:0]    block_low;
    logic                out_valid;
    logic                out_ready;
    logic [WordW-1:0]    result_high;
    logic [WordW-1:0]    result_low;
    logic                cfg_we;
    logic [CfgIdxW-1:0]  cfg_index;
    logic [WordW-1:0]    cfg_data;

    cbc_scoreboard cbc_sb;
    bit            calm;
    int            sent_items;
    logic [127:0]  last_cipher;

    aes256_cbc_block_cipher_top u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .command       (command),
        .restart_chain (restart_chain),
        .block_high    (block_high),
        .block_low     (block_low),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .result_high   (result_high),
        .result_low    (result_low),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    // Clock with a 2 ns period.
    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Hard limit on the run length.
    initial
    begin
        #4ms;
        $display("aes256_cbc_block_cipher_top test failed");
        $finish;
    end

    // Check every result taken from the output channel.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            cbc_sb.check_result(result_high, result_low);
    end

    // Receiver stalls in random bursts until the calm part of the run.
    initial
    begin
        out_ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (!calm && $urandom_range(0, 3) == 0)
            begin
                out_ready <= 1'b0;
                repeat ($urandom_range(1, 17)) @(negedge clk);
            end
            out_ready <= 1'b1;
            repeat ($urandom_range(1, 20)) @(negedge clk);
        end
    end

    function automatic logic [63:0] rand_word();
        case ($urandom_range(0, 5))
            0:       return '0;
            1:       return '1;
            default: return {$urandom, $urandom};
        endcase
    endfunction

    // Present one item and hold it until the handshake; valid stays high afterwards.
    task automatic send_block(logic cmd, logic restart, logic [63:0] hi, logic [63:0] lo);
        @(negedge clk);
        in_valid      <= 1'b1;
        command       <= cmd;
        restart_chain <= restart;
        block_high    <= hi;
        block_low     <= lo;
        do @(posedge clk); while (!in_ready);
        last_cipher = cbc_sb.note_input(cmd, restart, hi, lo);
        if (cmd == CMD_DECRYPT) last_cipher = {hi, lo};
        sent_items++;
    endtask

    task automatic pause_sender(int cycles);
        @(negedge clk);
        in_valid <= 1'b0;
        repeat (cycles - 1) @(negedge clk);
    endtask

    // Wait until every prediction has been matched, with the sender quiet.
    task automatic drain();
        pause_sender(1);
        while (cbc_sb.pending_blocks.size() != 0) @(posedge clk);
        repeat (4) @(negedge clk);
    endtask

    // One register write; key writes are followed by time for the schedule rebuild.
    task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [63:0] value);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(negedge clk);
        cfg_we    <= 1'b0;
        cbc_sb.write_reg(idx, value);
        if (idx <= REG_KEY3) repeat (60) @(negedge clk);
    endtask

    task automatic load_key(logic [63:0] k0, logic [63:0] k1, logic [63:0] k2, logic [63:0] k3);
        write_reg(REG_KEY0, k0);
        write_reg(REG_KEY1, k1);
        write_reg(REG_KEY2, k2);
        write_reg(REG_KEY3, k3);
    endtask

    // Random CBC traffic: mostly chained runs, some restarts and decrypts of recent output.
    task automatic random_traffic(int count);
        logic cmd;
        logic restart;
        for (int n = 0; n < count; n++)
        begin
            if (!calm && $urandom_range(0, 3) == 0) pause_sender($urandom_range(1, 17));
            cmd = 1'($urandom_range(0, 1));
            restart = ($urandom_range(0, 7) == 0);
            if (cmd == CMD_DECRYPT && $urandom_range(0, 1) == 1)
                send_block(cmd, restart, last_cipher[127:64], last_cipher[63:0]);
            else
                send_block(cmd, restart, rand_word(), rand_word());
            if (sent_items > 700) calm = 1'b1;
        end
    endtask

    initial
    begin
        cbc_sb        = new();
        calm          = 1'b0;
        sent_items    = 0;
        last_cipher   = '0;
        rst_n         = 1'b0;
        in_valid      = 1'b0;
        command       = CMD_ENCRYPT;
        restart_chain = 1'b0;
        block_high    = '0;
        block_low     = '0;
        cfg_we        = 1'b0;
        cfg_index     = REG_KEY0;
        cfg_data      = '0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Indexes past the register list must be ignored.
        write_reg(3'd6, '1);
        write_reg(3'd7, 64'hdead_beef_0123_4567);

        // Standard key, IV still at its reset value: restart loads zero.
        load_key(64'h0001020304050607, 64'h08090a0b0c0d0e0f,
                 64'h1011121314151617, 64'h18191a1b1c1d1e1f);
        send_block(CMD_ENCRYPT, 1'b1, 64'h0011223344556677, 64'h8899aabbccddeeff);
        send_block(CMD_DECRYPT, 1'b1, last_cipher[127:64], last_cipher[63:0]);
        send_block(CMD_ENCRYPT, 1'b0, '0, '0);
        send_block(CMD_ENCRYPT, 1'b0, '1, '1);
        send_block(CMD_DECRYPT, 1'b0, '1, '0);
        send_block(CMD_DECRYPT, 1'b0, '0, '1);
        drain();

        // IV write takes effect only on the next restart.
        write_reg(REG_IV_HIGH, '1);
        write_reg(REG_IV_LOW, '1);
        send_block(CMD_ENCRYPT, 1'b0, 64'h8000000000000000, 64'h1);
        send_block(CMD_ENCRYPT, 1'b1, 64'h8000000000000000, 64'h1);
        send_block(CMD_DECRYPT, 1'b1, '0, '0);
        send_block(CMD_DECRYPT, 1'b0, '1, '1);
        drain();

        // A single key word changes the whole schedule.
        write_reg(REG_KEY2, '1);
        send_block(CMD_ENCRYPT, 1'b1, 64'h0123456789abcdef, 64'hfedcba9876543210);
        send_block(CMD_DECRYPT, 1'b0, last_cipher[127:64], last_cipher[63:0]);
        drain();

        // Extreme keys.
        load_key('0, '0, '0, '0);
        send_block(CMD_ENCRYPT, 1'b1, '0, '0);
        send_block(CMD_DECRYPT, 1'b1, '0, '0);
        drain();
        load_key('1, '1, '1, '1);
        write_reg(REG_IV_HIGH, '0);
        write_reg(REG_IV_LOW, '0);
        send_block(CMD_ENCRYPT, 1'b1, '1, '1);
        send_block(CMD_DECRYPT, 1'b0, '1, '1);
        drain();

        // Random phases, each with its own key and IV setting.
        for (int ph = 0; ph < 6; ph++)
        begin
            case (ph)
                0:       load_key('0, '1, '0, '1);
                1:       write_reg(CfgIdxW'($urandom_range(REG_KEY0, REG_KEY3)), rand_word());
                default: load_key(rand_word(), rand_word(), rand_word(), rand_word());
            endcase
            write_reg(REG_IV_HIGH, rand_word());
            write_reg(REG_IV_LOW, rand_word());
            random_traffic(130);
            drain();
        end

        while (cbc_sb.pending_blocks.size() != 0) @(posedge clk);
        repeat (40) @(posedge clk);
        $display("Covered %0d blocks (%0d encrypt, %0d decrypt) over several keys and IVs;",
                 sent_items, cbc_sb.enc_count, cbc_sb.dec_count);
        $display("%0d results checked, %0d mismatches.", cbc_sb.checked, cbc_sb.errors);
        if (cbc_sb.errors == 0)
            $display("aes256_cbc_block_cipher_top test passed");
        else
            $display("aes256_cbc_block_cipher_top test failed");
        $finish;
    end
endmodule
